// ----- src/lrmt_pkg.sv -----
// Package: shared types, codes and timing constants of the LCD mode timing block.
package lrmt_pkg;

   // Command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // Register indexes
   localparam logic [3:0] ADDR_CTRL = 4'd0;
   localparam logic [3:0] ADDR_STAT = 4'd1;
   localparam logic [3:0] ADDR_SCY  = 4'd2;
   localparam logic [3:0] ADDR_SCX  = 4'd3;
   localparam logic [3:0] ADDR_LY   = 4'd4;
   localparam logic [3:0] ADDR_LYC  = 4'd5;
   localparam logic [3:0] ADDR_DMA  = 4'd6;
   localparam logic [3:0] ADDR_BGP  = 4'd7;
   localparam logic [3:0] ADDR_OBP0 = 4'd8;
   localparam logic [3:0] ADDR_OBP1 = 4'd9;
   localparam logic [3:0] ADDR_WY   = 4'd10;
   localparam logic [3:0] ADDR_WX   = 4'd11;

   // Mode codes
   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   // Timing defaults and fixed event positions
   localparam int DOTS_PER_LINE_DEF   = 456;
   localparam int LINES_PER_FRAME_DEF = 154;
   localparam int DOT_MODE3           = 80;
   localparam int DOT_MODE0           = 252;
   localparam int LAST_VISIBLE_LINE   = 143;
   localparam int VBLANK_LINE         = 144;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       vblank_strobe;
      logic       lcd_irq;
      logic       render_line;
      logic       dma_start;
      logic [7:0] dma_page;
      logic [7:0] current_line;
      logic [1:0] current_mode;
   } rsp_type;

   // Register file settings the timing logic needs
   typedef struct packed {
      logic       lcd_enable;
      logic [3:0] stat_enables;
      logic [7:0] lyc;
   } lcd_cfg_type;

   // Timing status after the item, plus the events it fired
   typedef struct packed {
      logic [7:0] line;
      logic [1:0] mode;
      logic       coincidence;
      logic       vblank_strobe;
      logic       lcd_irq;
      logic       render_line;
   } lcd_status_type;

endpackage

// ----- src/lrmt_timing.sv -----
// Dot and line counters, mode sequencing, LY update and stat events.
module lrmt_timing #(
   parameter int DOTS_PER_LINE   = lrmt_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = lrmt_pkg::LINES_PER_FRAME_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  lrmt_pkg::lcd_cfg_type  cfg,
   output lrmt_pkg::lcd_status_type status
);
   import lrmt_pkg::*;

   localparam int DOT_W  = $clog2(DOTS_PER_LINE);
   localparam int LINE_W = $clog2(LINES_PER_FRAME);

   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] vcount_ff, vcount_in;
   logic [7:0]        line_ff, line_in;
   logic [1:0]        mode_ff, mode_in;
   logic              coin_ff, coin_in;
   logic              vbl, lirq, rend;
   logic [DOT_W:0]    dot_sum;
   logic [LINE_W:0]   line_sum;

   always_comb begin
      line_in = line_ff;
      mode_in = mode_ff;
      coin_in = coin_ff;
      vbl     = 1'b0;
      lirq    = 1'b0;
      rend    = 1'b0;
      dot_in    = dot_ff;
      vcount_in = vcount_ff;
      dot_sum   = {1'b0, dot_ff} + {{DOT_W{1'b0}}, 1'b1};
      line_sum  = {1'b0, vcount_ff} + {{LINE_W{1'b0}}, 1'b1};
      if (tick) begin
         if (cfg.lcd_enable) begin
            if (dot_ff == '0) begin
               line_in = 8'(vcount_ff);
               coin_in = (line_in == cfg.lyc);
               if (coin_in && cfg.stat_enables[3]) lirq = 1'b1;
            end
            if (vcount_ff <= LINE_W'(LAST_VISIBLE_LINE)) begin
               if (dot_ff == '0) begin
                  mode_in = MODE_OAM;
                  if (cfg.stat_enables[2]) lirq = 1'b1;
               end else if (dot_ff == DOT_W'(DOT_MODE3)) begin
                  mode_in = MODE_TRANSFER;
               end else if (dot_ff == DOT_W'(DOT_MODE0)) begin
                  mode_in = MODE_HBLANK;
                  rend    = 1'b1;
                  if (cfg.stat_enables[0]) lirq = 1'b1;
               end
            end else if (vcount_ff == LINE_W'(VBLANK_LINE) && dot_ff == '0) begin
               mode_in = MODE_VBLANK;
               vbl     = 1'b1;
               if (cfg.stat_enables[1]) lirq = 1'b1;
            end
         end
         // Counters advance whether or not the display is enabled
         if (dot_sum >= (DOT_W+1)'(DOTS_PER_LINE)) begin
            dot_in = '0;
            if (line_sum >= (LINE_W+1)'(LINES_PER_FRAME)) vcount_in = '0;
            else vcount_in = line_sum[LINE_W-1:0];
         end else begin
            dot_in = dot_sum[DOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= '0;
         vcount_ff <= '0;
         line_ff   <= '0;
         mode_ff   <= MODE_OAM;
         coin_ff   <= 1'b0;
      end else begin
         dot_ff    <= dot_in;
         vcount_ff <= vcount_in;
         line_ff   <= line_in;
         mode_ff   <= mode_in;
         coin_ff   <= coin_in;
      end
   end

   assign status.line          = line_in;
   assign status.mode          = mode_in;
   assign status.coincidence   = coin_in;
   assign status.vblank_strobe = vbl;
   assign status.lcd_irq       = lirq;
   assign status.render_line   = rend;

endmodule

// ----- src/lrmt_regs.sv -----
// Register file: control, stat enables, scroll, compare, palettes, window, dma strobe.
module lrmt_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [3:0]               reg_addr,
   input  logic [7:0]               write_data,
   input  lrmt_pkg::lcd_status_type status,
   output lrmt_pkg::lcd_cfg_type    cfg,
   output logic [7:0]               read_data,
   output logic                     dma_start,
   output logic [7:0]               dma_page
);
   import lrmt_pkg::*;

   logic [7:0] ctrl_ff, scy_ff, scx_ff, lyc_ff, bgp_ff, obp0_ff, obp1_ff, wy_ff, wx_ff;
   logic [3:0] stat_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         stat_en_ff <= '0;
         scy_ff     <= '0;
         scx_ff     <= '0;
         lyc_ff     <= '0;
         bgp_ff     <= '0;
         obp0_ff    <= '0;
         obp1_ff    <= '0;
         wy_ff      <= '0;
         wx_ff      <= '0;
      end else if (wr_en) begin
         case (reg_addr)
            ADDR_CTRL: ctrl_ff    <= write_data;
            ADDR_STAT: stat_en_ff <= write_data[6:3];
            ADDR_SCY:  scy_ff     <= write_data;
            ADDR_SCX:  scx_ff     <= write_data;
            ADDR_LYC:  lyc_ff     <= write_data;
            ADDR_BGP:  bgp_ff     <= write_data;
            ADDR_OBP0: obp0_ff    <= write_data;
            ADDR_OBP1: obp1_ff    <= write_data;
            ADDR_WY:   wy_ff      <= write_data;
            ADDR_WX:   wx_ff      <= write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      read_data = '0;
      if (rd_en) begin
         case (reg_addr)
            ADDR_CTRL: read_data = ctrl_ff;
            ADDR_STAT: read_data = {1'b0, stat_en_ff, status.coincidence, status.mode};
            ADDR_SCY:  read_data = scy_ff;
            ADDR_SCX:  read_data = scx_ff;
            ADDR_LY:   read_data = status.line;
            ADDR_LYC:  read_data = lyc_ff;
            ADDR_BGP:  read_data = bgp_ff;
            ADDR_OBP0: read_data = obp0_ff;
            ADDR_OBP1: read_data = obp1_ff;
            ADDR_WY:   read_data = wy_ff;
            ADDR_WX:   read_data = wx_ff;
            default:   read_data = '0;
         endcase
      end
   end

   assign dma_start = wr_en && (reg_addr == ADDR_DMA);
   assign dma_page  = dma_start ? write_data : 8'd0;

   assign cfg.lcd_enable   = ctrl_ff[7];
   assign cfg.stat_enables = stat_en_ff;
   assign cfg.lyc          = lyc_ff;

endmodule

// ----- src/lcd_register_and_mode_timing.sv -----
// Top level: scanline LCD controller register file and mode timing with output buffering.
//
// Each item is one dot tick, one register read or one register write, and
// produces exactly one result item. An item is accepted in any cycle with
// req_stall low: its work (counter advance, mode events, register access)
// is done in the cycle of acceptance, and the result is registered.
// A two-entry output buffer (result register plus skid register) keeps the
// input side open while a result waits; req_stall rises only when both
// entries are full, so throughput is one item per cycle whenever the
// result side takes one per cycle. Mode 2 starts at dot 0, mode 3 at dot 80
// and mode 0 at dot 252 on lines 0 to 143; line 144 enters mode 1 with a
// vblank pulse. Events and LY updates happen only while control bit 7 is
// set; the dot and line counters always run. A dma register write raises
// dma_start with the page byte; the copy itself and pixel drawing are left
// to the surrounding logic.
module lcd_register_and_mode_timing #(
   parameter int DOTS_PER_LINE   = lrmt_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = lrmt_pkg::LINES_PER_FRAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lrmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrmt_pkg::rsp_type rsp_data
);
   import lrmt_pkg::*;

   logic           push, pop;
   lcd_cfg_type    cfg;
   lcd_status_type status;
   rsp_type        result;
   logic [7:0]     read_data, dma_page;
   logic           dma_start;

   rsp_type        main_ff, skid_ff;
   logic           main_valid_ff, skid_valid_ff;

   // Take an item whenever the skid entry is free
   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = skid_valid_ff;

   lrmt_timing #(
      .DOTS_PER_LINE  (DOTS_PER_LINE),
      .LINES_PER_FRAME(LINES_PER_FRAME)
   ) u_timing (
      .clock (clock),
      .reset (reset),
      .tick  (push && (req_data.cmd == CMD_TICK)),
      .cfg   (cfg),
      .status(status)
   );

   lrmt_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push && (req_data.cmd == CMD_WRITE)),
      .rd_en     (push && (req_data.cmd == CMD_READ)),
      .reg_addr  (req_data.reg_addr),
      .write_data(req_data.write_data),
      .status    (status),
      .cfg       (cfg),
      .read_data (read_data),
      .dma_start (dma_start),
      .dma_page  (dma_page)
   );

   // Assemble the result item for the item being accepted
   always_comb begin
      result.read_data     = read_data;
      result.vblank_strobe = status.vblank_strobe;
      result.lcd_irq       = status.lcd_irq;
      result.render_line   = status.render_line;
      result.dma_start     = dma_start;
      result.dma_page      = dma_page;
      result.current_line  = status.line;
      result.current_mode  = status.mode;
   end

   // Output buffer: the main entry is the older one, the skid entry holds
   // a result that arrived while the main entry was stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= result;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // Skid entry is never occupied without an older result in front of it
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry full while result register empty");

   // Vblank pulse comes with mode 1 on the vblank line
   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.vblank_strobe) |->
         (rsp_data.current_mode == MODE_VBLANK &&
          rsp_data.current_line == 8'(VBLANK_LINE)))
      else $error("vblank pulse without mode 1 on the vblank line");

   // Render strobe comes with entry to hblank
   a_render_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.render_line) |-> (rsp_data.current_mode == MODE_HBLANK))
      else $error("render strobe outside hblank");

   // A dma write is never also a read or a tick
   a_dma_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dma_start) |->
         (rsp_data.read_data == 8'd0 && !rsp_data.vblank_strobe &&
          !rsp_data.lcd_irq && !rsp_data.render_line))
      else $error("dma strobe mixed with read data or timing events");

endmodule
